// ===== sv/tfbs_pkg.sv =====
// Shared types, register indexes and word/CRC functions for the telemetry frame
// bit serializer. No dependencies; used by every module of the block.
`default_nettype none
package tfbs_pkg;

	localparam logic [3:0] WORD_LEN_LONG  = 4'd13;
	localparam logic [3:0] WORD_LEN_SHORT = 4'd12;
	localparam logic [1:0] POS_CRC_START  = 2'd2;
	localparam logic [7:0] CRC_POLY_RESET = 8'h07;

	localparam logic [7:0] CTRL_EXC_FLAG  = 8'h7E;
	localparam logic [7:0] CTRL_EXC_HIGH  = 8'hFE;
	localparam logic [7:0] CTRL_EXC_ONES  = 8'hFF;

	// register indexes of the configuration port
	localparam logic REG_CRC_POLY   = 1'b0;
	localparam logic REG_LONG_WORDS = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic tx_bit;
		logic word_end;
		logic frame_end;
	} out_t;

	// one encoded line word, left-aligned: bit 12 goes out first
	typedef struct packed {
		logic [12:0] bits;
		logic        wide;
		logic        is_crc;
	} word_t;

	function automatic logic [7:0] crc_feed(logic [7:0] acc, logic [7:0] b,
			logic [7:0] poly);
		logic [7:0] c;
		c = acc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic word_t encode_word(logic [7:0] b, logic wide, logic is_crc);
		word_t      w;
		logic       ctrl;
		logic       par;
		logic [7:0] rev;
		ctrl = wide && (b != CTRL_EXC_FLAG) && (b != CTRL_EXC_HIGH)
			&& (b != CTRL_EXC_ONES);
		// odd parity over data and control bit
		par = ~((^b) ^ ctrl);
		for (int j = 0; j < 8; j++) begin
			rev[7 - j] = b[j];
		end
		if (wide) begin
			w.bits = {1'b0, rev, ctrl, par, 2'b11};
		end else begin
			w.bits = {1'b0, rev, par, 2'b11, 1'b1};
		end
		w.wide   = wide;
		w.is_crc = is_crc;
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== sv/tfbs_frame_ctrl.sv =====
// Input stage: frame position, CRC-8 accumulator and a two-word buffer of
// encoded words waiting for the bit shifter. Depends on tfbs_pkg.
`default_nettype none
module tfbs_frame_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire tfbs_pkg::in_t  in_data,
	input  wire logic [7:0]     crc_poly,
	input  wire logic           long_words,
	output logic                word_valid,
	output tfbs_pkg::word_t     word,
	input  wire logic           word_take
);

	logic [1:0]      pos_q;
	logic [7:0]      crc_q;
	logic [1:0]      buf_cnt_s1;
	tfbs_pkg::word_t slot0_s1;
	tfbs_pkg::word_t slot1_s1;

	logic       accept;
	logic       feed;
	logic [7:0] crc_next;
	logic [7:0] crc_send;

	assign word_valid = (buf_cnt_s1 != 2'd0);
	assign word       = slot0_s1;
	// take a new byte only once the buffer drains this cycle
	assign in_ready   = (buf_cnt_s1 == 2'd0) || ((buf_cnt_s1 == 2'd1) && word_take);
	assign accept     = in_valid && in_ready;
	assign feed       = (pos_q == tfbs_pkg::POS_CRC_START);
	assign crc_next   = tfbs_pkg::crc_feed(crc_q, in_data.data_byte, crc_poly);
	assign crc_send   = feed ? crc_next : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			crc_q <= 8'd0;
		end else if (accept) begin
			if (in_data.last_byte) begin
				pos_q <= 2'd0;
				crc_q <= 8'd0;
			end else if (feed) begin
				crc_q <= crc_next;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_s1 <= 2'd0;
		end else if (accept) begin
			buf_cnt_s1 <= in_data.last_byte ? 2'd2 : 2'd1;
		end else if (word_take) begin
			buf_cnt_s1 <= buf_cnt_s1 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot0_s1 <= tfbs_pkg::encode_word(in_data.data_byte, long_words, 1'b0);
			slot1_s1 <= tfbs_pkg::encode_word(crc_send, long_words, 1'b1);
		end else if (word_take) begin
			slot0_s1 <= slot1_s1;
		end
	end

`ifndef SYNTH
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd3)
		else $error("frame position beyond saturation");
	a_buf_range: assert property (@(posedge clk) disable iff (!arst_n)
		buf_cnt_s1 != 2'd3)
		else $error("word buffer overfilled");
	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		word_take |-> word_valid)
		else $error("word taken from empty buffer");
	a_crc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.last_byte) |=> (crc_q == 8'd0 && pos_q == 2'd0))
		else $error("CRC state not cleared after last byte");
`endif

endmodule
`default_nettype wire

// ===== sv/tfbs_bit_shifter.sv =====
// Bit shifter: loads encoded words from the input stage and moves them out one
// line bit per transfer through a registered output. Depends on tfbs_pkg.
`default_nettype none
module tfbs_bit_shifter (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            word_valid,
	input  wire tfbs_pkg::word_t word,
	output logic                 word_take,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output tfbs_pkg::out_t       out_data
);

	logic [12:0]    sh_q;
	logic [3:0]     rem_q;
	logic           crc_q;
	logic           out_valid_q;
	tfbs_pkg::out_t out_q;

	logic adv;
	logic last_bit;

	assign adv       = !out_valid_q || out_ready;
	assign last_bit  = (rem_q == 4'd1);
	// fetch a word when the shifter is empty, or the next word as the last bit of this one leaves
	assign word_take = word_valid && ((rem_q == 4'd0) || (adv && last_bit));
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= (rem_q != 4'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (rem_q != 4'd0)) begin
			out_q.tx_bit    <= sh_q[12];
			out_q.word_end  <= last_bit;
			out_q.frame_end <= last_bit && crc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 4'd0;
			crc_q <= 1'b0;
		end else if (word_take) begin
			rem_q <= word.wide ? tfbs_pkg::WORD_LEN_LONG : tfbs_pkg::WORD_LEN_SHORT;
			crc_q <= word.is_crc;
		end else if (adv && (rem_q != 4'd0)) begin
			rem_q <= rem_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (word_take) begin
			sh_q <= word.bits;
		end else if (adv && (rem_q != 4'd0)) begin
			sh_q <= {sh_q[11:0], 1'b1};
		end
	end

`ifndef SYNTH
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= tfbs_pkg::WORD_LEN_LONG)
		else $error("bit count out of range");
	a_frame_on_word_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.frame_end) |-> out_q.word_end)
		else $error("frame end without word end");
	a_stop_bit_high: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.word_end) |-> out_q.tx_bit)
		else $error("final stop bit not high");
`endif

endmodule
`default_nettype wire

// ===== sv/telemetry_frame_bit_serializer_top.sv =====
// Top level of the telemetry frame bit serializer: configuration registers,
// input stage and bit shifter. Depends on tfbs_pkg, tfbs_frame_ctrl, tfbs_bit_shifter.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   input    | in_valid / in_ready    | in_data  (data_byte, last_byte)
//   output   | out_valid / out_ready  | out_data (tx_bit, word_end, frame_end)
//   config   | cfg_we                 | cfg_index, cfg_wdata
//
// One line bit leaves per cycle while the output is not stalled; a byte is a word of 13
// line bits in long mode and 12 in short mode, and a last byte is followed by its CRC word.
// A byte is accepted as the shifter takes the last buffered word of the previous one.
// On an idle block a byte's word goes from the input buffer to the shifter, then out.
// Reset clears the CRC, frame position, buffer and output; registers take 0x07 and 1.
// A stalled output holds its bit and the shifter; an empty shifter still loads a word.
`default_nettype none
module telemetry_frame_bit_serializer_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire tfbs_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output tfbs_pkg::out_t      out_data,
	input  wire logic           cfg_we,
	input  wire logic           cfg_index,
	input  wire logic [7:0]     cfg_wdata
);

	logic [7:0]      crc_poly_q;
	logic            long_words_q;
	logic            word_valid;
	logic            word_take;
	tfbs_pkg::word_t word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q   <= tfbs_pkg::CRC_POLY_RESET;
			long_words_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				tfbs_pkg::REG_CRC_POLY: begin
					crc_poly_q <= cfg_wdata;
				end
				tfbs_pkg::REG_LONG_WORDS: begin
					long_words_q <= cfg_wdata[0];
				end
				default: begin
					crc_poly_q <= crc_poly_q;
				end
			endcase
		end
	end

	tfbs_frame_ctrl u_frame_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.crc_poly   (crc_poly_q),
		.long_words (long_words_q),
		.word_valid (word_valid),
		.word       (word),
		.word_take  (word_take)
	);

	tfbs_bit_shifter u_bit_shifter (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word       (word),
		.word_take  (word_take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire
